// ----- hw/rtl/hpg_pkg.sv -----
// Shared types and constants of the hypotrochoid point generator.
package hpg_pkg;

	// Request and response payloads
	typedef struct packed {
		logic [3:0]  pen_index;
		logic [17:0] step_index;
	} hpg_in_t;

	typedef struct packed {
		logic signed [19:0] x_position;
		logic signed [19:0] y_position;
		logic               first_point;
		logic               last_point;
		logic               past_end;
	} hpg_out_t;

	// Point flags carried down the pipeline
	typedef struct packed {
		logic first_point;
		logic last_point;
		logic past_end;
	} hpg_flags_t;

	// Side data that rides along the divider
	typedef struct packed {
		logic [31:0] ang_main;
		logic        neg;
		hpg_flags_t  flags;
	} hpg_div_tag_t;

	// Curve constants
	localparam int STEPS_PER_TURN = 628;
	localparam int MAX_PENS       = 16;
	localparam int SCALE_BITS     = 40;
	localparam logic [30:0] TURN_PER_STEP = 31'd1749927105;

	// Phase offset to 2^-40 turn: 2^40/36000 = 2^35/1125, split into
	// whole part and remainder; remainder divided by reciprocal multiply
	localparam logic [24:0] PHASE_TURN_INT    = 25'd30541989;
	localparam logic [9:0]  PHASE_TURN_REM    = 10'd743;
	localparam logic [26:0] PHASE_RECIP       = 27'd122167959;
	localparam int          PHASE_RECIP_SHIFT = 37;

	// Divider geometry: two lanes, one quotient bit per stage
	localparam int DIV_LANES = 2;
	localparam int DIV_BITS  = 59;
	localparam int DEN_BITS  = 16;

	// CORDIC geometry, Q.30 datapath
	localparam int CORDIC_ITERS = 24;
	localparam int CW           = 33;
	localparam logic signed [CW-1:0] CORDIC_START = 33'sd652032874;
	localparam logic signed [CW-1:0] ATAN_TURNS [CORDIC_ITERS] = '{
		33'sh20000000, 33'sh12E4051E, 33'sh09FB385B, 33'sh051111D4,
		33'sh028B0D43, 33'sh0145D7E1, 33'sh00A2F61E, 33'sh00517C55,
		33'sh0028BE53, 33'sh00145F2F, 33'sh000A2F98, 33'sh000517CC,
		33'sh00028BE6, 33'sh000145F3, 33'sh0000A2FA, 33'sh0000517D,
		33'sh000028BE, 33'sh0000145F, 33'sh00000A30, 33'sh00000518,
		33'sh0000028C, 33'sh00000146, 33'sh000000A3, 33'sh00000051
	};

	// Configuration register indexes
	localparam logic [2:0] REG_OUTER_RADIUS = 3'd0;
	localparam logic [2:0] REG_INNER_RADIUS = 3'd1;
	localparam logic [2:0] REG_PEN_OFFSET   = 3'd2;
	localparam logic [2:0] REG_TURN_COUNT   = 3'd3;
	localparam logic [2:0] REG_PEN_COUNT    = 3'd4;
	localparam logic [2:0] REG_PHASE_OFFSET = 3'd5;

endpackage

// ----- hw/rtl/hpg_divider.sv -----
// Pipelined restoring divider, two lanes, one quotient bit per stage.
module hpg_divider
	import hpg_pkg::*;
(
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  hpg_div_tag_t                       in_tag,
	input  logic [DIV_LANES-1:0][DIV_BITS-1:0] num,
	input  logic [DIV_LANES-1:0][DEN_BITS-1:0] den,
	output logic                               out_valid,
	output hpg_div_tag_t                       out_tag,
	output logic [DIV_LANES-1:0][DIV_BITS-1:0] quo
);

	// Per stage: shifting dividend/quotient word and partial remainder
	logic [DIV_LANES-1:0][DIV_BITS-1:0] nq_s  [DIV_BITS];
	logic [DIV_LANES-1:0][DEN_BITS-1:0] rem_s [DIV_BITS];
	logic [DIV_LANES-1:0][DIV_BITS-1:0] nq_d  [DIV_BITS];
	logic [DIV_LANES-1:0][DEN_BITS-1:0] rem_d [DIV_BITS];
	hpg_div_tag_t                       tag_s [DIV_BITS];
	logic [DIV_BITS-1:0]                valid_s;

	// Form one quotient bit in every stage and lane
	always_comb begin
		logic [DIV_BITS-1:0] src_nq;
		logic [DEN_BITS-1:0] src_rem;
		logic [DEN_BITS:0]   trial;
		logic                ge;
		for (int k = 0; k < DIV_BITS; k++) begin
			for (int l = 0; l < DIV_LANES; l++) begin
				src_nq  = (k == 0) ? num[l] : nq_s[(k == 0) ? 0 : k - 1][l];
				src_rem = (k == 0) ? '0 : rem_s[(k == 0) ? 0 : k - 1][l];
				trial   = {src_rem, src_nq[DIV_BITS-1]};
				ge      = trial >= {1'b0, den[l]};
				if (ge) begin
					rem_d[k][l] = DEN_BITS'(trial - {1'b0, den[l]});
				end else begin
					rem_d[k][l] = trial[DEN_BITS-1:0];
				end
				nq_d[k][l] = {src_nq[DIV_BITS-2:0], ge};
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[DIV_BITS-2:0], in_valid};
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_BITS; k++) begin
				nq_s[k]  <= nq_d[k];
				rem_s[k] <= rem_d[k];
				tag_s[k] <= (k == 0) ? in_tag : tag_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	assign out_valid = valid_s[DIV_BITS-1];
	assign out_tag   = tag_s[DIV_BITS-1];
	assign quo       = nq_s[DIV_BITS-1];

endmodule

// ----- hw/rtl/hpg_cordic.sv -----
// Pipelined two-lane CORDIC rotator giving cos and sin of turn fractions.
module hpg_cordic
	import hpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  hpg_flags_t            in_flags,
	input  logic [1:0][31:0]      angle,
	output logic                  out_valid,
	output hpg_flags_t            out_flags,
	output logic [1:0][CW-1:0]    cos_out,
	output logic [1:0][CW-1:0]    sin_out
);

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;

	logic signed [1:0][CW-1:0] x_s [CORDIC_ITERS];
	logic signed [1:0][CW-1:0] y_s [CORDIC_ITERS];
	logic signed [1:0][CW-1:0] z_s [CORDIC_ITERS];
	logic        [1:0][1:0]    quad_s [CORDIC_ITERS];
	hpg_flags_t                flags_s [CORDIC_ITERS];
	logic [CORDIC_ITERS-1:0]   valid_s;

	logic signed [1:0][CW-1:0] x_d [CORDIC_ITERS];
	logic signed [1:0][CW-1:0] y_d [CORDIC_ITERS];
	logic signed [1:0][CW-1:0] z_d [CORDIC_ITERS];

	logic [1:0][CW-1:0] cos_fin;
	logic [1:0][CW-1:0] sin_fin;
	hpg_flags_t         flags_fin;
	logic               valid_fin;

	// One micro-rotation per stage
	always_comb begin
		logic signed [CW-1:0] sx, sy, sz, dx, dy;
		for (int k = 0; k < CORDIC_ITERS; k++) begin
			for (int l = 0; l < 2; l++) begin
				if (k == 0) begin
					sx = CORDIC_START;
					sy = '0;
					sz = $signed({3'b000, angle[l][29:0]});
				end else begin
					sx = x_s[(k == 0) ? 0 : k - 1][l];
					sy = y_s[(k == 0) ? 0 : k - 1][l];
					sz = z_s[(k == 0) ? 0 : k - 1][l];
				end
				dx = sy >>> k;
				dy = sx >>> k;
				if (!sz[CW-1]) begin
					x_d[k][l] = sx - dx;
					y_d[k][l] = sy + dy;
					z_d[k][l] = sz - ATAN_TURNS[k];
				end else begin
					x_d[k][l] = sx + dx;
					y_d[k][l] = sy - dy;
					z_d[k][l] = sz + ATAN_TURNS[k];
				end
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s   <= '0;
			valid_fin <= 1'b0;
		end else if (en) begin
			valid_s   <= {valid_s[CORDIC_ITERS-2:0], in_valid};
			valid_fin <= valid_s[CORDIC_ITERS-1];
		end
	end

	// Advance rotation state and apply the quadrant in the last stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < CORDIC_ITERS; k++) begin
				x_s[k] <= x_d[k];
				y_s[k] <= y_d[k];
				z_s[k] <= z_d[k];
				if (k == 0) begin
					quad_s[k][0] <= angle[0][31:30];
					quad_s[k][1] <= angle[1][31:30];
					flags_s[k]   <= in_flags;
				end else begin
					quad_s[k]  <= quad_s[(k == 0) ? 0 : k - 1];
					flags_s[k] <= flags_s[(k == 0) ? 0 : k - 1];
				end
			end
			for (int l = 0; l < 2; l++) begin
				case (quad_s[CORDIC_ITERS-1][l])
					QUAD_I: begin
						cos_fin[l] <= x_s[CORDIC_ITERS-1][l];
						sin_fin[l] <= y_s[CORDIC_ITERS-1][l];
					end
					QUAD_II: begin
						cos_fin[l] <= -y_s[CORDIC_ITERS-1][l];
						sin_fin[l] <= x_s[CORDIC_ITERS-1][l];
					end
					QUAD_III: begin
						cos_fin[l] <= -x_s[CORDIC_ITERS-1][l];
						sin_fin[l] <= -y_s[CORDIC_ITERS-1][l];
					end
					default: begin
						cos_fin[l] <= y_s[CORDIC_ITERS-1][l];
						sin_fin[l] <= -x_s[CORDIC_ITERS-1][l];
					end
				endcase
			end
			flags_fin <= flags_s[CORDIC_ITERS-1];
		end
	end

	assign out_valid = valid_fin;
	assign out_flags = flags_fin;
	assign cos_out   = cos_fin;
	assign sin_out   = sin_fin;

endmodule

// ----- hw/rtl/hypotrochoid_point_generator.sv -----
// Top level of the hypotrochoid point generator: config, pipeline, output skid.
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    hpg_in_t  (pen_index, step_index)
//  rsp      out        rsp_valid/rsp_ready    hpg_out_t (x, y, flags)
//  cfg      in         cfg_valid/cfg_ready    cfg_index (3 bit), cfg_data (16 bit)
//
// One point enters per cycle while req_ready is high; results show on rsp in request order.
// The pipeline holds the 59-stage roll-angle and pen-angle divider and the 25-stage CORDIC.
// Reset restores the register defaults and empties every stage; cfg is always ready.
// A stalled response lands in a one-entry skid; req_ready drops only while it is full,
// and the whole pipeline then holds.
module hypotrochoid_point_generator
	import hpg_pkg::*;
#(
	parameter int ANGLE_BITS = 24,
	parameter int FRAC_BITS  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  hpg_in_t     req_data,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output hpg_out_t    rsp_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [4:0] PEN_CLAMP = (MAX_PENS < 31) ? 5'(MAX_PENS) : 5'd31;
	localparam logic [40:0] ROUND_ANG = 41'(1) << (39 - ANGLE_BITS);
	localparam logic signed [45:0] ROUND_COORD = 46'(1) << (29 - FRAC_BITS);
	localparam logic signed [45:0] COORD_MAX = 46'sd524287;
	localparam logic signed [45:0] COORD_MIN = -46'sd524288;

	// Round a 2^-40 turn fraction to ANGLE_BITS and widen to a 32-bit turn
	function automatic logic [31:0] to_turn(input logic [39:0] a);
		logic [40:0] sum;
		logic [40:0] sh;
		sum = {1'b0, a} + ROUND_ANG;
		sh  = sum >> (40 - ANGLE_BITS);
		return 32'(sh[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
	endfunction

	// Configuration registers
	logic [9:0]  outer_radius_q, inner_radius_q, pen_offset_q;
	logic [7:0]  turn_count_q;
	logic [4:0]  pen_count_q;
	logic [15:0] phase_offset_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_radius_q <= 10'd100;
			inner_radius_q <= 10'd50;
			pen_offset_q   <= 10'd25;
			turn_count_q   <= 8'd5;
			pen_count_q    <= 5'd1;
			phase_offset_q <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OUTER_RADIUS: outer_radius_q <= cfg_data[9:0];
				REG_INNER_RADIUS: inner_radius_q <= cfg_data[9:0];
				REG_PEN_OFFSET:   pen_offset_q   <= cfg_data[9:0];
				REG_TURN_COUNT:   turn_count_q   <= cfg_data[7:0];
				REG_PEN_COUNT:    pen_count_q    <= cfg_data[4:0];
				REG_PHASE_OFFSET: phase_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Derived register values; keep stable while points are in flight (not enforced here)
	logic signed [10:0] diff;
	logic [9:0]         mag;
	logic [9:0]         divisor;
	logic [4:0]         pens_eff;
	logic [17:0]        last_idx;

	always_comb begin
		diff     = $signed({1'b0, outer_radius_q}) - $signed({1'b0, inner_radius_q});
		mag      = diff[10] ? 10'(-diff) : diff[9:0];
		divisor  = (inner_radius_q == '0) ? 10'd1 : inner_radius_q;
		if (pen_count_q == '0) begin
			pens_eff = 5'd1;
		end else if (pen_count_q > PEN_CLAMP) begin
			pens_eff = PEN_CLAMP;
		end else begin
			pens_eff = pen_count_q;
		end
		last_idx = 18'(STEPS_PER_TURN * turn_count_q);
	end

	// Phase offset as a 2^-40 turn fraction; a write settles through phase_rem_q and
	// phase_base_q into phase_turn_q, long before any point reaches the roll-angle sum
	logic [25:0] phase_rem_q;
	logic [39:0] phase_base_q;
	logic [39:0] phase_turn_q;
	logic [52:0] phase_prod;

	assign phase_prod = 53'(phase_rem_q) * 53'(PHASE_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_rem_q  <= '0;
			phase_base_q <= '0;
			phase_turn_q <= '0;
		end else begin
			phase_rem_q  <= 26'(phase_offset_q * PHASE_TURN_REM);
			phase_base_q <= 40'(phase_offset_q * PHASE_TURN_INT);
			phase_turn_q <= phase_base_q + 40'(phase_prod >> PHASE_RECIP_SHIFT);
		end
	end

	// Pipeline enable: hold everything while the skid is occupied
	logic en;
	logic skid_valid_q;
	hpg_out_t skid_q;

	assign en        = !skid_valid_q;
	assign req_ready = en;

	// Stage registers
	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic [27:0] mp_s1;
	logic [39:0] amain_s1;
	logic [3:0]  pen_s1;
	logic        neg_s1;
	hpg_flags_t  flags_s1;
	logic [DIV_BITS-1:0] rollnum_s2, pennum_s2;
	hpg_div_tag_t tag_s2;
	logic [39:0] aroll_s3;
	logic [31:0] ang1_s3;
	hpg_flags_t  flags_s3;
	logic [31:0] ang1_s4, ang2_s4;
	hpg_flags_t  flags_s4;
	logic signed [43:0] px1_s5, px2_s5, py1_s5, py2_s5;
	hpg_flags_t  flags_s5;
	logic signed [45:0] xs_s6, ys_s6;
	hpg_flags_t  flags_s6;
	hpg_out_t    res_s7;

	// Divider and CORDIC wiring
	logic         div_valid;
	hpg_div_tag_t div_tag;
	logic [DIV_LANES-1:0][DIV_BITS-1:0] div_quo;
	logic         cor_valid;
	hpg_flags_t   cor_flags;
	logic [1:0][CW-1:0] cor_cos, cor_sin;

	hpg_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s2),
		.in_tag    (tag_s2),
		.num       ({rollnum_s2, pennum_s2}),
		.den       ({DEN_BITS'(divisor), DEN_BITS'(pens_eff)}),
		.out_valid (div_valid),
		.out_tag   (div_tag),
		.quo       (div_quo)
	);

	hpg_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s4),
		.in_flags  (flags_s4),
		.angle     ({ang2_s4, ang1_s4}),
		.out_valid (cor_valid),
		.out_flags (cor_flags),
		.cos_out   (cor_cos),
		.sin_out   (cor_sin)
	);

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= div_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= cor_valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		logic [39:0] roll;
		logic signed [45:0] rx, ry;
		if (en) begin
			// s1: main angle product, roll numerator start, flags
			mp_s1    <= 28'(mag * req_data.step_index);
			amain_s1 <= 40'(req_data.step_index * TURN_PER_STEP);
			pen_s1   <= req_data.pen_index;
			neg_s1   <= diff[10];
			flags_s1.first_point <= req_data.step_index == '0;
			flags_s1.last_point  <= req_data.step_index == last_idx;
			flags_s1.past_end    <= (req_data.step_index > last_idx)
				|| ({1'b0, req_data.pen_index} >= pens_eff);
			// s2: roll numerator, main angle rounding, pen numerator
			rollnum_s2  <= DIV_BITS'(mp_s1 * TURN_PER_STEP);
			pennum_s2   <= DIV_BITS'(pen_s1) << SCALE_BITS;
			tag_s2.ang_main <= to_turn(amain_s1);
			tag_s2.neg      <= neg_s1;
			tag_s2.flags    <= flags_s1;
			// s3: roll angle sum mod one turn
			roll = div_tag.neg ? (40'd0 - div_quo[1][39:0]) : div_quo[1][39:0];
			aroll_s3 <= roll + div_quo[0][39:0] + phase_turn_q;
			ang1_s3  <= div_tag.ang_main;
			flags_s3 <= div_tag.flags;
			// s4: roll angle rounding
			ang1_s4  <= ang1_s3;
			ang2_s4  <= to_turn(aroll_s3);
			flags_s4 <= flags_s3;
			// s5: scale by radii
			px1_s5   <= diff * $signed(cor_cos[0]);
			py1_s5   <= diff * $signed(cor_sin[0]);
			px2_s5   <= $signed({1'b0, pen_offset_q}) * $signed(cor_cos[1]);
			py2_s5   <= $signed({1'b0, pen_offset_q}) * $signed(cor_sin[1]);
			flags_s5 <= cor_flags;
			// s6: combine circles
			xs_s6    <= 46'(px1_s5) + 46'(px2_s5);
			ys_s6    <= 46'(py1_s5) - 46'(py2_s5);
			flags_s6 <= flags_s5;
			// s7: round to Q.FRAC_BITS and saturate
			rx = (xs_s6 + ROUND_COORD) >>> (30 - FRAC_BITS);
			ry = (ys_s6 + ROUND_COORD) >>> (30 - FRAC_BITS);
			if (rx > COORD_MAX) begin
				res_s7.x_position <= 20'sd524287;
			end else if (rx < COORD_MIN) begin
				res_s7.x_position <= -20'sd524288;
			end else begin
				res_s7.x_position <= rx[19:0];
			end
			if (ry > COORD_MAX) begin
				res_s7.y_position <= 20'sd524287;
			end else if (ry < COORD_MIN) begin
				res_s7.y_position <= -20'sd524288;
			end else begin
				res_s7.y_position <= ry[19:0];
			end
			res_s7.first_point <= flags_s6.first_point;
			res_s7.last_point  <= flags_s6.last_point;
			res_s7.past_end    <= flags_s6.past_end;
		end
	end

	// Output register with skid: drain the skid first, else take the last stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (rsp_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!rsp_valid || rsp_ready) begin
			rsp_valid <= valid_s7;
		end else if (valid_s7) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (rsp_ready) begin
				rsp_data <= skid_q;
			end
		end else if (!rsp_valid || rsp_ready) begin
			rsp_data <= res_s7;
		end else begin
			skid_q <= res_s7;
		end
	end

endmodule

// ----- hw/rtl/hpg_checker.sv -----
// Port-level checks of the hypotrochoid point generator and their binding.
module hpg_checker
	import hpg_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     req_ready,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input hpg_out_t rsp_data,
	input logic     cfg_valid,
	input logic     cfg_ready
);

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled response changed");

	// Drop request ready only after a stalled response
	a_req_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> $past(rsp_valid) && !$past(rsp_ready))
		else $error("request ready low without a stalled response");

	// Take every configuration write at once
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write not taken");

	// Leave reset with no response pending
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid)
		else $error("response valid right after reset");

endmodule

bind hypotrochoid_point_generator hpg_checker u_hpg_checker (.*);
